// ===== design/ile_pkg.sv =====
// Shared types and constants for the indexed list engine.
package ile_pkg;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRIM   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load_item;
		logic start_walk;
		logic walk_en;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic err;
		logic need_walk;
		logic walk_idle;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/ile_ctrl.sv =====
// Command sequencer for the indexed list engine.
module ile_ctrl
	import ile_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t ctl
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.err || !stat.need_walk) begin
					state_d = S_FINISH;
				end else begin
					ctl.start_walk = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				ctl.walk_en = 1'b1;
				if (stat.walk_idle) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ile_dp.sv =====
// Datapath for the indexed list engine: entry store, fill count, walk and result register.
module ile_dp
	import ile_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               ctl,
	output dp_stat_t                stat,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ST_W-1:0]         status,
	output logic [CNT_W-1:0]        match_count,
	output logic                    found,
	output logic [CNT_W-1:0]        length
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VAL_W-1:0] entries_q [CAPACITY];

	logic [CMD_W-1:0]        cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           fill_nx;
	logic [CW-1:0]           rem_q;
	logic [AW-1:0]           ptr_q;
	logic [CW-1:0]           match_q;
	logic                    rd_issue;
	logic                    rd_pend_s1;
	logic [AW-1:0]           rd_addr_s1;
	logic signed [VAL_W-1:0] rdata_s1;
	logic [POS_W-1:0]        fill_ext;
	logic                    is_full;
	logic [ST_W-1:0]         status_d;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [VAL_W-1:0] mem_wdata;
	logic                    out_valid_q;
	logic [ST_W-1:0]         status_q;
	logic [CNT_W-1:0]        match_out_q;
	logic                    found_q;
	logic [CNT_W-1:0]        length_q;

	assign fill_ext = POS_W'(fill_q);
	assign is_full  = (fill_q == CW'(CAPACITY));

	always_comb begin
		status_d = ST_DONE;
		case (cmd_q)
			CMD_APPEND: begin
				if (is_full) status_d = ST_FULL;
			end
			CMD_REMOVE: begin
				if (pos_q >= fill_ext) status_d = ST_RANGE;
			end
			CMD_INSERT: begin
				if (is_full) status_d = ST_FULL;
				else if (pos_q > fill_ext) status_d = ST_RANGE;
			end
			CMD_TRIM: begin
				if (pos_q > fill_ext) status_d = ST_RANGE;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_comb begin
		fill_nx = fill_q;
		if (status_d == ST_DONE) begin
			case (cmd_q)
				CMD_APPEND: fill_nx = fill_q + CW'(1);
				CMD_INSERT: fill_nx = fill_q + CW'(1);
				CMD_REMOVE: fill_nx = fill_q - CW'(1);
				CMD_TRIM:   fill_nx = CW'(pos_q);
				default:    fill_nx = fill_q;
			endcase
		end
	end

	assign stat.err       = (status_d != ST_DONE);
	assign stat.need_walk = (cmd_q == CMD_REMOVE) || (cmd_q == CMD_INSERT)
		|| (cmd_q == CMD_SEARCH);
	assign stat.walk_idle = (rem_q == '0) && !rd_pend_s1;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign rd_issue = ctl.walk_en && (rem_q != '0);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= cmd;
			val_q <= value;
			pos_q <= position;
		end
		if (ctl.start_walk) begin
			case (cmd_q)
				CMD_REMOVE: begin
					ptr_q <= AW'(pos_q) + AW'(1);
				end
				CMD_INSERT: begin
					ptr_q <= AW'(fill_q) - AW'(1);
				end
				default: begin
					ptr_q <= '0;
				end
			endcase
		end else if (rd_issue) begin
			if (cmd_q == CMD_INSERT) ptr_q <= ptr_q - AW'(1);
			else ptr_q <= ptr_q + AW'(1);
		end
		if (rd_issue) begin
			rd_addr_s1 <= ptr_q;
		end
		if (ctl.finish) begin
			status_q    <= status_d;
			match_out_q <= CNT_W'(match_q);
			found_q     <= (match_q != '0);
			length_q    <= CNT_W'(fill_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rem_q       <= '0;
			match_q     <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				fill_q <= fill_nx;
			end
			if (ctl.start_walk) begin
				case (cmd_q)
					CMD_REMOVE: rem_q <= fill_q - CW'(pos_q) - CW'(1);
					CMD_INSERT: rem_q <= fill_q - CW'(pos_q);
					default:    rem_q <= fill_q;
				endcase
			end else if (rd_issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (ctl.load_item) begin
				match_q <= '0;
			end else if (rd_pend_s1 && (cmd_q == CMD_SEARCH) && (rdata_s1 == val_q)) begin
				match_q <= match_q + CW'(1);
			end
			rd_pend_s1 <= rd_issue;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = rdata_s1;
		if (rd_pend_s1 && (cmd_q == CMD_REMOVE)) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1 - AW'(1);
		end else if (rd_pend_s1 && (cmd_q == CMD_INSERT)) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1 + AW'(1);
		end else if (ctl.finish && (status_d == ST_DONE)) begin
			if (cmd_q == CMD_APPEND) begin
				mem_we    = 1'b1;
				mem_waddr = AW'(fill_q);
				mem_wdata = val_q;
			end else if (cmd_q == CMD_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_q);
				mem_wdata = val_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_q[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rdata_s1 <= entries_q[ptr_q];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_count = match_out_q;
	assign found       = found_q;
	assign length      = length_q;

endmodule

// ===== design/indexed_list_engine_core.sv =====
// Indexed list engine: ordered list of signed 32-bit values in a fixed store.
// Append, trim, rejected requests and unused commands go straight from check to result;
// remove, insert and search first walk the entries moved or scanned (up to CAPACITY),
// one entry per cycle.
// One transaction at a time; the next is accepted the cycle after the result is registered.
// Reset (arst_n low) empties the list; store contents are not cleared.
module indexed_list_engine_core
	import ile_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ST_W-1:0]         status,
	output logic [CNT_W-1:0]        match_count,
	output logic                    found,
	output logic [CNT_W-1:0]        length
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	ile_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (cmd),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.match_count (match_count),
		.found       (found),
		.length      (length)
	);

endmodule

// ===== sim/tb_indexed_list_engine_core.sv =====
// Testbench for indexed_list_engine_core: directed and random list commands against a predictor.
`timescale 1ns / 100ps

module tb_indexed_list_engine_core;
	import ile_pkg::*;

	localparam int LIST_CAP      = 64;
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_ITEMS   = 415;

	localparam logic [CMD_W-1:0] CMD_SPARE_0 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_1 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_2 = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [ST_W-1:0]  st;
		logic [CNT_W-1:0] count;
		logic             hit;
		logic [CNT_W-1:0] len;
	} list_result_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        cmd = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        match_count;
	logic                    found;
	logic [CNT_W-1:0]        length;

	logic signed [VAL_W-1:0] list_mem [LIST_CAP];
	int                      list_len = 0;
	list_result_t            pending_results [$];
	list_result_t            want;
	logic signed [VAL_W-1:0] value_pool [8];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	indexed_list_engine_core #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.match_count(match_count),
		.found(found),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic list_result_t predict_list_result(input logic [CMD_W-1:0] op,
			input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t r;
		int i;
		r = '{op: op, st: ST_DONE, count: '0, hit: 1'b0, len: '0};
		case (op)
			CMD_APPEND: begin
				if (list_len >= LIST_CAP) begin
					r.st = ST_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			CMD_REMOVE: begin
				if (int'(pos) >= list_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = int'(pos); i < list_len - 1; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			CMD_INSERT: begin
				if (list_len >= LIST_CAP) begin
					r.st = ST_FULL;
				end else if (int'(pos) > list_len) begin
					r.st = ST_RANGE;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			CMD_TRIM: begin
				if (int'(pos) > list_len)
					r.st = ST_RANGE;
				else
					list_len = int'(pos);
			end
			CMD_SEARCH: begin
				for (i = 0; i < list_len; i++)
					if (list_mem[i] == val)
						r.count = r.count + 1'b1;
			end
			default: ;
		endcase
		r.hit = (r.count != 0);
		r.len = CNT_W'(list_len);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(3) == 0)
			return $urandom;
		return value_pool[$urandom_range(7)];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_list_op(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		value <= val;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_list_result(op, val, pos));
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_list_op(input bit grow);
		int pick;
		logic [CMD_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		pick = $urandom_range(99);
		val = pick_value();
		pos = '0;
		op = CMD_SEARCH;
		if (pick < 3) begin
			case ($urandom_range(2))
				0: op = CMD_SPARE_0;
				1: op = CMD_SPARE_1;
				default: op = CMD_SPARE_2;
			endcase
			pos = POS_W'($urandom_range(127));
		end else if (pick < 8) begin
			op = CMD_W'($urandom_range(CMD_SEARCH));
			pos = POS_W'($urandom_range(127));
		end else begin
			pick = $urandom_range(99);
			if (grow) begin
				if (pick < 50) begin
					op = CMD_APPEND;
				end else if (pick < 80) begin
					op = CMD_INSERT;
					pos = POS_W'($urandom_range(list_len));
				end else if (pick < 92) begin
					op = CMD_SEARCH;
				end else if (pick < 97) begin
					op = CMD_REMOVE;
					pos = (list_len != 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
				end else begin
					op = CMD_TRIM;
					pos = POS_W'(list_len);
				end
			end else begin
				if (pick < 40) begin
					op = CMD_REMOVE;
					pos = (list_len != 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
				end else if (pick < 50) begin
					op = CMD_TRIM;
					pos = POS_W'($urandom_range(list_len, list_len / 2));
				end else if (pick < 70) begin
					op = CMD_SEARCH;
				end else if (pick < 80) begin
					op = CMD_APPEND;
				end else if (pick < 90) begin
					op = CMD_INSERT;
					pos = POS_W'($urandom_range(list_len));
				end else begin
					op = ($urandom_range(1) != 0) ? CMD_REMOVE : CMD_INSERT;
					pos = POS_W'(list_len + 1 + int'($urandom_range(2)));
				end
			end
		end
		send_list_op(op, val, pos);
	endtask

	task automatic test_empty_list;
		idle_pct = 0;
		stall_pct = 0;
		send_list_op(CMD_SEARCH, '0, '0);
		send_list_op(CMD_REMOVE, '0, '0);
		send_list_op(CMD_TRIM, '0, 1);
		send_list_op(CMD_TRIM, '0, 0);
		send_list_op(CMD_INSERT, 5, 1);
		send_list_op(CMD_SPARE_0, $urandom, 127);
		send_list_op(CMD_SPARE_1, $urandom, 0);
		send_list_op(CMD_SPARE_2, $urandom, 64);
		drain_results();
	endtask

	task automatic test_edit_ops;
		send_list_op(CMD_APPEND, 32'sh7fffffff, 0);
		send_list_op(CMD_APPEND, 32'sh80000000, 127);
		send_list_op(CMD_INSERT, -32'sd1, 0);
		send_list_op(CMD_INSERT, '0, POS_W'(list_len));
		send_list_op(CMD_SEARCH, 32'sh80000000, 0);
		send_list_op(CMD_SEARCH, -32'sd1, 0);
		send_list_op(CMD_REMOVE, '0, POS_W'(list_len));
		send_list_op(CMD_REMOVE, '0, 0);
		send_list_op(CMD_REMOVE, '0, POS_W'(list_len - 1));
		send_list_op(CMD_INSERT, 7, POS_W'(list_len + 1));
		send_list_op(CMD_TRIM, '0, POS_W'(list_len));
		send_list_op(CMD_SEARCH, 32'sh7fffffff, 0);
		send_list_op(CMD_REMOVE, '0, 127);
		send_list_op(CMD_TRIM, '0, 0);
		send_list_op(CMD_SEARCH, '0, 0);
		drain_results();
	endtask

	task automatic test_full_store;
		idle_pct = 31;
		stall_pct = 31;
		while (list_len < LIST_CAP)
			send_list_op(CMD_APPEND, pick_value(), POS_W'($urandom_range(127)));
		send_list_op(CMD_APPEND, pick_value(), 0);
		send_list_op(CMD_INSERT, pick_value(), POS_W'(LIST_CAP));
		send_list_op(CMD_INSERT, pick_value(), POS_W'(LIST_CAP + 1));
		send_list_op(CMD_INSERT, pick_value(), 0);
		send_list_op(CMD_SEARCH, value_pool[0], 0);
		send_list_op(CMD_TRIM, '0, POS_W'(LIST_CAP));
		send_list_op(CMD_TRIM, '0, POS_W'(LIST_CAP + 1));
		send_list_op(CMD_REMOVE, '0, POS_W'(LIST_CAP - 1));
		send_list_op(CMD_INSERT, pick_value(), 0);
		send_list_op(CMD_SEARCH, pick_value(), 0);
		send_list_op(CMD_REMOVE, '0, 0);
		send_list_op(CMD_TRIM, '0, 0);
		drain_results();
	endtask

	task automatic test_random_ops(input int idle, input int stall, input int n_items);
		bit grow;
		grow = 1'b1;
		idle_pct = idle;
		stall_pct = stall;
		repeat (n_items) begin
			if (list_len == 0)
				grow = 1'b1;
			else if (list_len == LIST_CAP && $urandom_range(7) == 0)
				grow = 1'b0;
			else if ($urandom_range(79) == 0)
				grow = !grow;
			random_list_op(grow);
		end
		drain_results();
	endtask

	// receiver freezes while the sender keeps offering, so the block backs up
	task automatic test_output_hold;
		idle_pct = 0;
		stall_pct = 0;
		hold_req <= hold_req + 1;
		repeat (12)
			random_list_op(1'b1);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: status %0d length %0d",
					status, length));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("cmd %0d status: got %0d, expected %0d",
						want.op, status, want.st));
				if (match_count !== want.count)
					report_mismatch($sformatf("cmd %0d match_count: got %0d, expected %0d",
						want.op, match_count, want.count));
				if (found !== want.hit)
					report_mismatch($sformatf("cmd %0d found: got %0d, expected %0d",
						want.op, found, want.hit));
				if (length !== want.len)
					report_mismatch($sformatf("cmd %0d length: got %0d, expected %0d",
						want.op, length, want.len));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		value_pool[0] = '0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh80000000;
		value_pool[3] = 32'sh7fffffff;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_ops();
		test_full_store();
		test_random_ops(0, 0, PHASE_ITEMS);
		test_random_ops(84, 0, PHASE_ITEMS);
		test_random_ops(0, 84, PHASE_ITEMS);
		test_random_ops(31, 31, PHASE_ITEMS);
		test_output_hold();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ile_pkg.sv
design/ile_ctrl.sv
design/ile_dp.sv
design/indexed_list_engine_core.sv
sim/tb_indexed_list_engine_core.sv
